### hw/rtl/rgc_pkg.sv
// shared types, constants and constant tables of the rgb gamma correction block
package rgc_pkg;

  localparam int unsigned NUM_STAGES = 21;
  localparam int unsigned EXP_STEPS  = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned LOG_W      = 19;
  localparam int unsigned ACC_W      = 31;
  localparam int unsigned COEF_W     = 30;
  localparam int unsigned ADDR_W     = 3;

  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_INV_GAMMA = 1'b1;

  localparam logic [15:0]      INV_GAMMA_RST = 16'd4096;
  localparam logic [ACC_W-1:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [17:0]      OUT_SCALE     = 18'd255999;
  localparam logic [15:0]      RECIP_125     = 16'd33555;
  localparam logic [6:0]       SHIFT_LIMIT   = 7'd31;

  typedef logic [LOG_W-1:0]  log_t;
  typedef log_t              log_tab_t [256];
  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t             coef_tab_t [EXP_STEPS];

  // log2 of a byte in q3.16 by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q16(input int unsigned x);
    logic [63:0] m;
    logic [63:0] res;
    int unsigned e;
    e = 0;
    for (int i = 0; i < 7; i++) begin
      if ((x >> (e + 1)) != 0) e++;
    end
    m   = 64'(x) << (30 - e);
    res = 64'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        res[i] = 1'b1;
        m      = m >> 1;
      end
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] log255;
    log255 = log2_q16(255);
    for (int x = 0; x < 256; x++) begin
      if (x == 0) tab[x] = '0;
      else        tab[x] = LOG_W'(log255 - log2_q16(x));
    end
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-2^-k) in q0.30 for k = 1..16
  function automatic coef_tab_t build_coef_tab();
    coef_tab_t   tab;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int k = 0; k < EXP_STEPS; k++) begin
      tab[k] = COEF_W'(c);
      c      = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam log_tab_t  LOG_DIFF = build_log_tab();
  localparam coef_tab_t EXP_COEF = build_coef_tab();

endpackage

### hw/rtl/rgc_in_if.sv
// input pixel channel: valid, ready and the three input channel bytes
interface rgc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

### hw/rtl/rgc_out_if.sv
// output pixel channel: valid, ready and the three corrected channel bytes
interface rgc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

### hw/rtl/rgc_channel.sv
// pipelined gamma datapath for one channel byte
module rgc_channel import rgc_pkg::*; (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic        enable_i,
  input  logic [15:0] inv_gamma_i,
  input  logic [7:0]  x_i,
  output logic [7:0]  y_o
);

  logic [7:0]           xs_q   [NUM_STAGES-1];
  log_t                 l_q;
  logic [6:0]           n_q    [EXP_STEPS+1];
  logic [FRAC_BITS-1:0] f_q    [EXP_STEPS];
  logic [ACC_W-1:0]     acc_q  [EXP_STEPS];
  logic [ACC_W-1:0]     acc_prev [EXP_STEPS];
  logic [ACC_W-1:0]     acc_d  [EXP_STEPS];
  logic [60:0]          mul_w  [EXP_STEPS];
  logic [ACC_W-1:0]     sh_q;
  logic [14:0]          div_q;
  logic [7:0]           y_q;

  logic [34:0] exp_prod;
  logic [22:0] exp_w;
  logic [48:0] scale_prod;
  logic [30:0] recip_prod;
  logic [8:0]  quot;
  logic [7:0]  y_d;

  assign exp_prod = 35'(l_q) * 35'(inv_gamma_i);
  assign exp_w    = exp_prod[34:12];

  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
    if (g == 0) begin : g_first
      assign acc_prev[g] = ONE_Q30;
    end else begin : g_rest
      assign acc_prev[g] = acc_q[g-1];
    end
    assign mul_w[g] = 61'(acc_prev[g]) * 61'(EXP_COEF[g]);
    assign acc_d[g] = f_q[g][FRAC_BITS-1-g] ? mul_w[g][60:30] : acc_prev[g];
  end

  assign scale_prod = 49'(sh_q) * 49'(OUT_SCALE);
  assign recip_prod = 31'(div_q) * 31'(RECIP_125);
  assign quot       = recip_prod[30:22];

  always_comb begin
    if (!enable_i) begin
      y_d = xs_q[NUM_STAGES-2];
    end else if (xs_q[NUM_STAGES-2] == 8'd0) begin
      y_d = 8'd0;
    end else if (quot > 9'd255) begin
      y_d = 8'd255;
    end else begin
      y_d = quot[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xs_q[0] <= x_i;
      for (int i = 1; i < NUM_STAGES - 1; i++) xs_q[i] <= xs_q[i-1];
      l_q <= LOG_DIFF[x_i];
      n_q[0] <= exp_w[22:16];
      f_q[0] <= exp_w[15:0];
      for (int i = 1; i < EXP_STEPS + 1; i++) n_q[i] <= n_q[i-1];
      for (int i = 1; i < EXP_STEPS; i++) f_q[i] <= f_q[i-1];
      for (int i = 0; i < EXP_STEPS; i++) acc_q[i] <= acc_d[i];
      if (n_q[EXP_STEPS] >= SHIFT_LIMIT) sh_q <= '0;
      else sh_q <= acc_q[EXP_STEPS-1] >> n_q[EXP_STEPS];
      div_q <= scale_prod[47:33];
      y_q   <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

### hw/rtl/rgb_gamma_correction.sv
// top level of the rgb gamma correction block with its register port
// Takes one RGB pixel per clock while the pipeline advances and returns it
// gamma corrected, each channel mapped to floor(min(255, 255.999 * (x/255)^p))
// with p = inverse_gamma/4096, or passed unchanged while correction_enable is
// 0. The datapath is a 21-stage pipeline (log table, exponent multiply, sixteen
// exp2 multiply steps, shift, scale, divide by reciprocal), and a new word is
// accepted every cycle unless a valid output is not taken, in which case the
// whole pipeline holds. Registers: correction_enable at 0x0, inverse_gamma
// at 0x4; write them only while no pixel is in flight.
module rgb_gamma_correction import rgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rgc_in_if.sink            pix_i,
  rgc_out_if.source         pix_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                  enable_q;
  logic [15:0]           inv_gamma_q;
  logic [NUM_STAGES-1:0] valid_q;
  logic                  adv;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      inv_gamma_q <= INV_GAMMA_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ENABLE:    enable_q    <= pwdata[0];
        REG_INV_GAMMA: inv_gamma_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE:    prdata = {31'd0, enable_q};
      REG_INV_GAMMA: prdata = {16'd0, inv_gamma_q};
      default:       prdata = '0;
    endcase
  end

  assign adv         = !valid_q[NUM_STAGES-1] || pix_o.ready;
  assign pix_i.ready = adv;
  assign pix_o.valid = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], pix_i.valid};
    end
  end

  rgc_channel u_red (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .enable_i    (enable_q),
    .inv_gamma_i (inv_gamma_q),
    .x_i         (pix_i.red_in),
    .y_o         (pix_o.red_out)
  );

  rgc_channel u_green (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .enable_i    (enable_q),
    .inv_gamma_i (inv_gamma_q),
    .x_i         (pix_i.green_in),
    .y_o         (pix_o.green_out)
  );

  rgc_channel u_blue (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .enable_i    (enable_q),
    .inv_gamma_i (inv_gamma_q),
    .x_i         (pix_i.blue_in),
    .y_o         (pix_o.blue_out)
  );

endmodule
